// ----- src/csvs_pkg.sv -----
//------------------------------------------------------------------------------
// csvs_pkg: shared types and constants of the CSV field splitter
// Character codes, result kinds, register indexes and the queue entry type.
//------------------------------------------------------------------------------
package csvs_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] SEP_RESET = 8'd44;
    localparam logic [9:0] COUNT_MAX = 10'd1023;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_EOF  = 2'd1;
    localparam logic [1:0] KIND_EOR  = 2'd2;

    localparam logic CFG_SEP_A = 1'b0;
    localparam logic CFG_SEP_B = 1'b1;

    typedef enum logic [4:0] {
        M_START  = 5'b00001,
        M_PLAIN  = 5'b00010,
        M_QUOTED = 5'b00100,
        M_QSEEN  = 5'b01000,
        M_AFTER  = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [9:0] field_index;
        logic       stream_final;
    } t_result;

    typedef struct packed {
        logic    two;
        t_result res0;
        t_result res1;
    } t_entry;

endpackage

// ----- src/csv_field_splitter.sv -----
//------------------------------------------------------------------------------
// csv_field_splitter: CSV field and record splitter
// Turns a byte stream into field data words, end-of-field and end-of-record marks.
//------------------------------------------------------------------------------
// A result passes through the entry queue and then the output register.
// Throughput: one input word per cycle while o_stall is low; the output emits one
// word per cycle while not stalled, so a line end with content gives two words.
// The entry queue of QUEUE_DEPTH entries absorbs output stalls and line ends.
// Reset: synchronous, active low; separators return to comma, parser to field start.
module csv_field_splitter import csvs_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic [9:0] o_field_index,
    output logic       o_stream_final,
    output logic       o_last_of_run
);

    logic   push, pop, empty, full;
    t_entry front_entry, queue_entry;

    assign o_stall = full;

    csvs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (i_valid && !full),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_push         (push),
        .o_entry        (front_entry)
    );

    csvs_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_empty (empty),
        .o_full  (full),
        .o_entry (queue_entry)
    );

    csvs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_entry        (queue_entry),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_field_index  (o_field_index),
        .o_stream_final (o_stream_final),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ----- src/csvs_front.sv -----
//------------------------------------------------------------------------------
// csvs_front: byte classifier and parse state machine
// Accepts one input word a cycle while i_accept is high and builds a queue entry of zero to two results.
//------------------------------------------------------------------------------
module csvs_front import csvs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [7:0] r_sep_a;
    logic [7:0] r_sep_b;
    t_mode      r_mode, n_mode;
    logic       r_cr, n_cr;
    logic       r_content, n_content;
    logic [9:0] r_count, n_count;

    logic       is_sep;
    logic       is_quote;
    logic [9:0] count_inc;
    logic [1:0] n_res;
    t_result    res_data;
    t_result    res_eof;

    assign is_sep    = (i_in_byte == r_sep_a) || (i_in_byte == r_sep_b);
    assign is_quote  = (i_in_byte == CH_QUOTE);
    assign count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 10'd1;

    always_comb begin
        res_data = '{kind: KIND_DATA, data_byte: i_in_byte,
                     field_index: r_count, stream_final: 1'b0};
        res_eof  = '{kind: KIND_EOF, data_byte: 8'd0,
                     field_index: r_count, stream_final: 1'b0};
        n_mode    = r_mode;
        n_cr      = r_cr;
        n_content = r_content;
        n_count   = r_count;
        n_res     = 2'd0;
        o_entry.two  = 1'b0;
        o_entry.res0 = res_data;
        o_entry.res1 = '{kind: KIND_EOR, data_byte: 8'd0,
                         field_index: count_inc, stream_final: 1'b0};
        if (i_end_of_input) begin
            n_cr      = 1'b0;
            n_mode    = M_START;
            n_count   = 10'd0;
            n_content = 1'b0;
            if (r_content) begin
                n_res                     = 2'd2;
                o_entry.res0              = res_eof;
                o_entry.res1.stream_final = 1'b1;
            end
        end else if (r_cr && (i_in_byte == CH_LF)) begin
            n_cr = 1'b0;
        end else if ((i_in_byte == CH_CR) || (i_in_byte == CH_LF)) begin
            n_cr      = (i_in_byte == CH_CR);
            n_mode    = M_START;
            n_count   = 10'd0;
            n_content = 1'b0;
            if (r_content) begin
                n_res        = 2'd2;
                o_entry.res0 = res_eof;
            end else begin
                n_res        = 2'd1;
                o_entry.res0 = '{kind: KIND_EOR, data_byte: 8'd0,
                                 field_index: r_count, stream_final: 1'b0};
            end
        end else begin
            n_cr      = 1'b0;
            n_content = 1'b1;
            n_res     = 2'd1;
            case (r_mode)
                M_PLAIN, M_AFTER: begin
                    if (is_sep) begin
                        n_mode       = M_START;
                        n_count      = count_inc;
                        o_entry.res0 = res_eof;
                    end
                end
                M_QUOTED: begin
                    if (is_quote) begin
                        n_mode = M_QSEEN;
                        n_res  = 2'd0;
                    end
                end
                M_QSEEN: begin
                    if (is_quote) begin
                        n_mode = M_QUOTED;
                    end else if (is_sep) begin
                        n_mode       = M_START;
                        n_count      = count_inc;
                        o_entry.res0 = res_eof;
                    end else begin
                        n_mode = M_AFTER;
                    end
                end
                default: begin
                    if (is_quote) begin
                        n_mode = M_QUOTED;
                        n_res  = 2'd0;
                    end else if (is_sep) begin
                        n_mode       = M_START;
                        n_count      = count_inc;
                        o_entry.res0 = res_eof;
                    end else begin
                        n_mode = M_PLAIN;
                    end
                end
            endcase
        end
        o_entry.two = (n_res == 2'd2);
        o_push      = i_accept && (n_res != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_a   <= SEP_RESET;
            r_sep_b   <= SEP_RESET;
            r_mode    <= M_START;
            r_cr      <= 1'b0;
            r_content <= 1'b0;
            r_count   <= 10'd0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SEP_A: r_sep_a <= i_cfg_data;
                    CFG_SEP_B: r_sep_b <= i_cfg_data;
                    default:   r_sep_a <= r_sep_a;
                endcase
            end
            if (i_accept) begin
                r_mode    <= n_mode;
                r_cr      <= n_cr;
                r_content <= n_content;
                r_count   <= n_count;
            end
        end
    end

endmodule

// ----- src/csvs_fifo.sv -----
//------------------------------------------------------------------------------
// csvs_fifo: short queue of result entries
// Register-based ring buffer between the parser and the output serializer.
//------------------------------------------------------------------------------
module csvs_fifo import csvs_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_empty,
    output logic   o_full,
    output t_entry o_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_FULL);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ----- src/csvs_back.sv -----
//------------------------------------------------------------------------------
// csvs_back: output serializer
// Takes queue entries and presents their results one word a cycle, while not stalled, from a register.
//------------------------------------------------------------------------------
module csvs_back import csvs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_entry     i_entry,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic [9:0] o_field_index,
    output logic       o_stream_final,
    output logic       o_last_of_run
);

    t_entry  r_ent;
    logic    r_have;
    logic    r_pos;
    logic    done;
    t_result cur;

    assign done  = !r_have || (!i_stall && (r_pos || !r_ent.two));
    assign o_pop = done && !i_empty;
    assign cur   = r_pos ? r_ent.res1 : r_ent.res0;

    assign o_valid        = r_have;
    assign o_kind         = cur.kind;
    assign o_data_byte    = cur.data_byte;
    assign o_field_index  = cur.field_index;
    assign o_stream_final = cur.stream_final;
    assign o_last_of_run  = r_pos || !r_ent.two;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_pos  <= 1'b0;
        end else if (o_pop) begin
            r_have <= 1'b1;
            r_pos  <= 1'b0;
        end else if (done) begin
            r_have <= 1'b0;
            r_pos  <= 1'b0;
        end else if (r_have && !i_stall) begin
            r_pos <= 1'b1;
        end
    end

endmodule

// ----- src/csvs_checker.sv -----
//------------------------------------------------------------------------------
// csvs_checker: port-level assertions for the CSV field splitter
// Checks output word consistency and the hold of a stalled output word.
//------------------------------------------------------------------------------
module csvs_checker import csvs_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_kind,
    input logic [7:0] o_data_byte,
    input logic [9:0] o_field_index,
    input logic       o_stream_final,
    input logic       o_last_of_run
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_data_byte)
            && $stable(o_field_index) && $stable(o_last_of_run))
        else $error("stalled output word changed");

    a_mark_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_DATA) |-> (o_data_byte == 8'd0))
        else $error("mark word carries a data byte");

    a_eor_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_EOR) |-> o_last_of_run)
        else $error("record end is not last of its run");

    a_final_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stream_final |-> (o_kind == KIND_EOR))
        else $error("stream final flag on a non record end");

    a_eof_then_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_kind == KIND_EOF) && !o_last_of_run
            |=> o_valid && (o_kind == KIND_EOR))
        else $error("field end in a two-word run not followed by record end");

endmodule

bind csv_field_splitter csvs_checker u_csvs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_kind         (o_kind),
    .o_data_byte    (o_data_byte),
    .o_field_index  (o_field_index),
    .o_stream_final (o_stream_final),
    .o_last_of_run  (o_last_of_run)
);

// ----- sim/csv_field_splitter_checker.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// csv_field_splitter_checker: result checker for the CSV field splitter
// Watches the configuration port and both channels, tracks the separators and
// the parser state, predicts the result words of every accepted input word and
// compares each accepted result word, field by field, with the oldest prediction.
//------------------------------------------------------------------------------
module csv_field_splitter_checker import csvs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_data_byte,
    input  logic [9:0] i_field_index,
    input  logic       i_stream_final,
    input  logic       i_last_of_run,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        t_result res;
        logic    last;
    } t_split_word;

    logic [7:0]  sep_one;
    logic [7:0]  sep_two;
    t_mode       mode_now;
    logic        cr_seen;
    logic        line_busy;
    logic [9:0]  fields_done;
    t_result     step_words[$];
    t_split_word words_due[$];

    function automatic void emit(input logic [1:0] kind, input logic [7:0] b,
                                 input logic [9:0] idx, input logic fin);
        t_result r;
        r.kind         = kind;
        r.data_byte    = b;
        r.field_index  = idx;
        r.stream_final = fin;
        step_words = {step_words, r};
    endfunction

    function automatic void close_field();
        emit(KIND_EOF, 8'h00, fields_done, 1'b0);
        if (fields_done != COUNT_MAX) begin
            fields_done = fields_done + 10'd1;
        end
    endfunction

    function automatic void close_line(input logic fin);
        if (line_busy) begin
            close_field();
        end
        emit(KIND_EOR, 8'h00, fields_done, fin);
        mode_now    = M_START;
        line_busy   = 1'b0;
        fields_done = '0;
    endfunction

    function automatic void predict_split(input logic [7:0] b, input logic eoi);
        logic        is_sep;
        logic        skip;
        t_split_word w;
        is_sep = (b == sep_one) || (b == sep_two);
        skip   = !eoi && cr_seen && (b == CH_LF);
        step_words.delete();
        cr_seen = 1'b0;
        if (eoi) begin
            if (line_busy) begin
                close_line(1'b1);
            end else begin
                mode_now    = M_START;
                fields_done = '0;
            end
        end else if (!skip) begin
            if (b == CH_CR || b == CH_LF) begin
                cr_seen = (b == CH_CR);
                close_line(1'b0);
            end else begin
                line_busy = 1'b1;
                case (mode_now)
                    M_PLAIN, M_AFTER: begin
                        if (is_sep) begin
                            mode_now = M_START;
                            close_field();
                        end else begin
                            emit(KIND_DATA, b, fields_done, 1'b0);
                        end
                    end
                    M_QUOTED: begin
                        if (b == CH_QUOTE) begin
                            mode_now = M_QSEEN;
                        end else begin
                            emit(KIND_DATA, b, fields_done, 1'b0);
                        end
                    end
                    M_QSEEN: begin
                        if (b == CH_QUOTE) begin
                            mode_now = M_QUOTED;
                            emit(KIND_DATA, b, fields_done, 1'b0);
                        end else if (is_sep) begin
                            mode_now = M_START;
                            close_field();
                        end else begin
                            mode_now = M_AFTER;
                            emit(KIND_DATA, b, fields_done, 1'b0);
                        end
                    end
                    default: begin
                        if (b == CH_QUOTE) begin
                            mode_now = M_QUOTED;
                        end else if (is_sep) begin
                            mode_now = M_START;
                            close_field();
                        end else begin
                            mode_now = M_PLAIN;
                            emit(KIND_DATA, b, fields_done, 1'b0);
                        end
                    end
                endcase
            end
        end
        foreach (step_words[i]) begin
            w.res  = step_words[i];
            w.last = (i == step_words.size() - 1);
            words_due = {words_due, w};
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_split_word got;
        t_split_word want;
        if (!i_rst_n) begin
            sep_one      = SEP_RESET;
            sep_two      = SEP_RESET;
            mode_now     = M_START;
            cr_seen      = 1'b0;
            line_busy    = 1'b0;
            fields_done  = '0;
            words_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.res.kind         = i_kind;
                got.res.data_byte    = i_data_byte;
                got.res.field_index  = i_field_index;
                got.res.stream_final = i_stream_final;
                got.last             = i_last_of_run;
                if (words_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display({"%0t: unexpected word kind=%0d byte=%02h index=%0d",
                                  " final=%0b last=%0b"},
                                 $time, got.res.kind, got.res.data_byte,
                                 got.res.field_index, got.res.stream_final, got.last);
                    end
                end else begin
                    want = words_due.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display({"%0t: mismatch, expected kind=%0d byte=%02h",
                                      " index=%0d final=%0b last=%0b, got kind=%0d",
                                      " byte=%02h index=%0d final=%0b last=%0b"},
                                     $time, want.res.kind, want.res.data_byte,
                                     want.res.field_index, want.res.stream_final,
                                     want.last, got.res.kind, got.res.data_byte,
                                     got.res.field_index, got.res.stream_final,
                                     got.last);
                        end
                    end
                end
            end
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_SEP_A) begin
                    sep_one = i_cfg_data;
                end else begin
                    sep_two = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_split(i_in_byte, i_end_of_input);
            end
        end
        o_pending = words_due.size();
    end

endmodule

// ----- sim/csv_field_splitter_tb.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// csv_field_splitter_tb: top-level testbench of the CSV field splitter
// Drives a directed opening sequence, a long line of empty fields and
// random CSV records with noise under several separator settings, with bursty
// input and a stalling receiver. A checker module beside the block does the
// predicting and comparing; this module only drives and gives the verdict.
//------------------------------------------------------------------------------
module csv_field_splitter_tb;
    import csvs_pkg::*;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_COMB} t_rx_pattern;

    localparam logic [8:0] OPENING_WORDS [27] = '{
        {1'b0, CH_LF}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, ","},
        {1'b0, CH_QUOTE}, {1'b0, ","}, {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE},
        {1'b0, CH_QUOTE}, {1'b0, "x"}, {1'b0, CH_QUOTE}, {1'b0, CH_CR},
        {1'b0, CH_LF}, {1'b0, "a"}, {1'b0, CH_QUOTE}, {1'b0, CH_CR},
        {1'b0, CH_CR}, {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE}, {1'b0, CH_LF},
        {1'b0, CH_QUOTE}, {1'b0, ","}, {1'b1, 8'h5A}, {1'b1, 8'hA5},
        {1'b0, "z"}, {1'b0, CH_CR}, {1'b1, 8'h00}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       end_of_input;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] out_kind;
    logic [7:0] out_data_byte;
    logic [9:0] out_field_index;
    logic       out_stream_final;
    logic       out_last_of_run;
    int         fail_count;
    int         pending;

    logic [7:0] sep_a;
    logic [7:0] sep_b;
    int         burst_left;
    int         sent_count;
    logic       hold_req;

    csv_field_splitter u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_in_byte      (in_byte),
        .i_end_of_input (end_of_input),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_kind         (out_kind),
        .o_data_byte    (out_data_byte),
        .o_field_index  (out_field_index),
        .o_stream_final (out_stream_final),
        .o_last_of_run  (out_last_of_run)
    );

    csv_field_splitter_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .i_end_of_input (end_of_input),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_kind         (out_kind),
        .i_data_byte    (out_data_byte),
        .i_field_index  (out_field_index),
        .i_stream_final (out_stream_final),
        .i_last_of_run  (out_last_of_run),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_word(input logic [7:0] b, input logic eoi);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 5);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        in_byte      <= b;
        end_of_input <= eoi;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_count++;
    endtask

    // Waits until every predicted word has arrived, then lets the pipeline
    // settle so that words which cause no result have left the block too.
    task automatic wait_idle();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_seps(input logic [7:0] a, input logic [7:0] b);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SEP_A;
        cfg_data  <= a;
        @(posedge clk);
        cfg_index <= CFG_SEP_B;
        cfg_data  <= b;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sep_a = a;
        sep_b = b;
    endtask

    function automatic logic [7:0] field_byte(input logic allow_sep);
        logic [7:0] b;
        if (allow_sep && $urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 1) ? sep_a : sep_b;
        end
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_CR || b == CH_LF || b == CH_QUOTE ||
                   (!allow_sep && (b == sep_a || b == sep_b)));
        return b;
    endfunction

    task automatic send_record();
        int n_fields;
        int len;
        int f;
        int j;
        int pick;
        n_fields = $urandom_range(0, 5);
        for (f = 0; f < n_fields; f++) begin
            if (f > 0) begin
                send_word($urandom_range(0, 1) ? sep_a : sep_b, 1'b0);
            end
            len = $urandom_range(0, 4);
            if ($urandom_range(0, 2) == 0) begin
                send_word(CH_QUOTE, 1'b0);
                for (j = 0; j < len; j++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_word(CH_QUOTE, 1'b0);
                        send_word(CH_QUOTE, 1'b0);
                    end else begin
                        send_word(field_byte(1'b1), 1'b0);
                    end
                end
                send_word(CH_QUOTE, 1'b0);
                if ($urandom_range(0, 3) == 0) begin
                    send_word(field_byte(1'b0), 1'b0);
                end
            end else begin
                for (j = 0; j < len; j++) begin
                    send_word((j > 0 && $urandom_range(0, 5) == 0) ? CH_QUOTE : field_byte(1'b0),
                              1'b0);
                end
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            send_word(CH_CR, 1'b0);
            send_word(CH_LF, 1'b0);
        end else if (pick < 7) begin
            send_word(CH_LF, 1'b0);
        end else if (pick < 9) begin
            send_word(CH_CR, 1'b0);
        end else begin
            send_word(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic send_noise();
        int         n;
        logic [7:0] b;
        n = $urandom_range(1, 6);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       b = sep_a;
                1:       b = sep_b;
                2:       b = CH_QUOTE;
                3:       b = CH_CR;
                4:       b = CH_LF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_word(b, $urandom_range(0, 19) == 0);
        end
    endtask

    task automatic run_random(input int quota);
        int start_count;
        start_count = sent_count;
        while (sent_count - start_count < quota) begin
            if ($urandom_range(0, 4) == 0) begin
                send_noise();
            end else begin
                send_record();
            end
        end
    endtask

    initial begin : receiver
        t_rx_pattern pattern;
        int          pattern_left;
        int          hold_left;
        logic        hold_done;
        out_stall    = 1'b0;
        pattern      = RX_FREE;
        pattern_left = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (pattern_left == 0) begin
                    pattern      = t_rx_pattern'($urandom_range(0, 3));
                    pattern_left = $urandom_range(20, 120);
                end
                pattern_left--;
                case (pattern)
                    RX_FREE:  out_stall <= 1'b0;
                    RX_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
                    RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                    default:  out_stall <= (pattern_left % 4 != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_SEP_A;
        cfg_data     = 8'h00;
        in_valid     = 1'b0;
        in_byte      = 8'h00;
        end_of_input = 1'b0;
        sep_a        = SEP_RESET;
        sep_b        = SEP_RESET;
        burst_left   = 0;
        sent_count   = 0;
        hold_req     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (OPENING_WORDS[i]) begin
            send_word(OPENING_WORDS[i][7:0], OPENING_WORDS[i][8]);
        end
        wait_idle();

        // The receiver holds off while a long line of empty fields is
        // offered, so the block fills and stalls.
        hold_req = 1'b1;
        repeat (40) send_word(sep_a, 1'b0);
        send_word("q", 1'b0);
        send_word(CH_CR, 1'b0);
        wait_idle();

        run_random(50);
        set_seps(";", 8'h09);
        run_random(45);
        set_seps(8'h00, 8'hFF);
        run_random(45);
        set_seps(CH_QUOTE, CH_CR);
        run_random(45);
        set_seps(CH_LF, "|");
        run_random(45);
        repeat (2) begin
            set_seps(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            run_random(45);
        end
        set_seps(SEP_RESET, SEP_RESET);
        run_random(30);

        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
src/csvs_pkg.sv
src/csvs_front.sv
src/csvs_fifo.sv
src/csvs_back.sv
src/csv_field_splitter.sv
src/csvs_checker.sv
sim/csv_field_splitter_checker.sv
sim/csv_field_splitter_tb.sv
